[rtl/core/atr_pkg.sv]
// ----------------------------------------------------------------------------
// Average true range: shared constants
// Field widths and the reset value of the period register.
// ----------------------------------------------------------------------------
package atr_pkg;

    localparam int CFG_W        = 7;
    localparam int TR_W         = 32;
    localparam int AVG_W        = 40;
    localparam int FRAC_BITS    = 8;
    localparam int PERIOD_RESET = 14;

endpackage

[rtl/core/atr_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module atr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/atr_fifo.sv]
// ----------------------------------------------------------------------------
// Average true range: decoupling queue
// A short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module atr_fifo #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (int'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (int'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    assign full      = (int'(count_reg) == DEPTH);
    assign not_empty = (count_reg != '0);
    assign head_data = slot_reg[rd_ptr_reg];

endmodule

[rtl/core/atr_front.sv]
// ----------------------------------------------------------------------------
// Average true range: front part
// Takes bars, works out the true range against the previous close and marks
// the first bar after reset, then queues the outcome for the back part.
// ----------------------------------------------------------------------------
module atr_front #(
    parameter int PRICE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [31:0]           bar_high,
    input  logic [31:0]           bar_low,
    input  logic [31:0]           bar_close,
    output logic                  q_push,
    output logic                  q_first,
    output logic [PRICE_BITS-1:0] q_tr,
    input  logic                  q_full
);

    logic [PRICE_BITS-1:0] prev_close_reg;
    logic                  have_prev_reg;
    logic [PRICE_BITS-1:0] high_p;
    logic [PRICE_BITS-1:0] low_p;
    logic [PRICE_BITS-1:0] hl;
    logic [PRICE_BITS-1:0] ch;
    logic [PRICE_BITS-1:0] cl;
    logic [PRICE_BITS-1:0] max_a;

    assign high_p = PRICE_BITS'(bar_high);
    assign low_p  = PRICE_BITS'(bar_low);

    always_comb
    begin
        hl    = (high_p >= low_p) ? high_p - low_p : '0;
        ch    = (prev_close_reg >= high_p) ? prev_close_reg - high_p : high_p - prev_close_reg;
        cl    = (prev_close_reg >= low_p) ? prev_close_reg - low_p : low_p - prev_close_reg;
        max_a = (ch > hl) ? ch : hl;
        q_tr  = (cl > max_a) ? cl : max_a;
    end

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;
    assign q_first  = !have_prev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_close_reg <= '0;
            have_prev_reg  <= 1'b0;
        end
        else if (q_push)
        begin
            prev_close_reg <= PRICE_BITS'(bar_close);
            have_prev_reg  <= 1'b1;
        end
    end

endmodule

[rtl/core/atr_back.sv]
// ----------------------------------------------------------------------------
// Average true range: back part
// Updates the ring of true ranges and the running sum, divides the sum by the
// period with a restoring divider once the window fills, and holds the result.
// ----------------------------------------------------------------------------
module atr_back #(
    parameter int MAX_PERIOD = 64,
    parameter int PRICE_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [$clog2(MAX_PERIOD+1)-1:0]    period,
    input  logic                               cfg_clear,
    input  logic                               q_not_empty,
    input  logic                               q_first,
    input  logic [PRICE_BITS-1:0]              q_tr,
    output logic                               q_pop,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [atr_pkg::TR_W-1:0]           true_range,
    output logic [atr_pkg::AVG_W-1:0]          average_range,
    output logic                               average_valid
);

    localparam int AW    = $clog2(MAX_PERIOD);
    localparam int PW    = $clog2(MAX_PERIOD + 1);
    localparam int SUM_W = PRICE_BITS + AW;
    localparam int DW    = SUM_W + atr_pkg::FRAC_BITS;
    localparam int CNT_W = $clog2(DW);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    state_t                     state_reg;
    logic [AW-1:0]              pos_reg;
    logic [PW-1:0]              filled_reg;
    logic [SUM_W-1:0]           sum_reg;
    logic [AW-1:0]              cur_pos_reg;
    logic [PRICE_BITS-1:0]      cur_tr_reg;
    logic [DW-1:0]              quo_reg;
    logic [PW-1:0]              rem_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [PRICE_BITS-1:0]      res_tr_reg;
    logic [atr_pkg::AVG_W-1:0]  res_avg_reg;
    logic                       res_vld_reg;
    logic                       out_valid_reg;
    logic [atr_pkg::TR_W-1:0]   out_tr_reg;
    logic [atr_pkg::AVG_W-1:0]  out_avg_reg;
    logic                       out_vld_reg;

    logic [AW-1:0]              pos_eff;
    logic [PRICE_BITS-1:0]      rd_data;
    logic                       window_full;
    logic [SUM_W-1:0]           sum_drop;
    logic [SUM_W-1:0]           sum_new;
    logic [PW-1:0]              filled_new;
    logic [PW-1:0]              pos_inc;
    logic [AW-1:0]              pos_wrap;
    logic [PW:0]                trial;
    logic [PW:0]                trial_sub;
    logic                       take;
    logic [PW-1:0]              rem_next;
    logic [DW-1:0]              quo_next;
    logic                       emit_load;

    assign pos_eff     = (PW'(pos_reg) >= period) ? '0 : pos_reg;
    assign window_full = (filled_reg >= period);
    assign sum_drop    = window_full ? SUM_W'(rd_data) : '0;
    assign sum_new     = sum_reg - sum_drop + SUM_W'(cur_tr_reg);
    assign filled_new  = window_full ? filled_reg : filled_reg + PW'(1);
    assign pos_inc     = PW'(cur_pos_reg) + PW'(1);
    assign pos_wrap    = (pos_inc >= period) ? '0 : AW'(pos_inc);

    assign trial     = {rem_reg, quo_reg[DW-1]};
    assign trial_sub = trial - {1'b0, period};
    assign take      = (trial >= {1'b0, period});
    assign rem_next  = take ? trial_sub[PW-1:0] : trial[PW-1:0];
    assign quo_next  = {quo_reg[DW-2:0], take};

    assign q_pop     = (state_reg == ST_IDLE) && q_not_empty;
    assign emit_load = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);

    atr_ram #(
        .WIDTH (PRICE_BITS),
        .DEPTH (MAX_PERIOD)
    ) u_ring (
        .clk     (clk),
        .wr_en   (state_reg == ST_UPDATE),
        .wr_addr (cur_pos_reg),
        .wr_data (cur_tr_reg),
        .rd_addr (pos_eff),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            filled_reg    <= '0;
            sum_reg       <= '0;
            cur_pos_reg   <= '0;
            cur_tr_reg    <= '0;
            quo_reg       <= '0;
            rem_reg       <= '0;
            cnt_reg       <= '0;
            res_tr_reg    <= '0;
            res_avg_reg   <= '0;
            res_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_tr_reg    <= '0;
            out_avg_reg   <= '0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            if (emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_clear)
            begin
                pos_reg    <= '0;
                filled_reg <= '0;
                sum_reg    <= '0;
            end
            else if (state_reg == ST_UPDATE)
            begin
                sum_reg    <= sum_new;
                filled_reg <= filled_new;
                pos_reg    <= pos_wrap;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_not_empty)
                    begin
                        if (q_first)
                        begin
                            res_tr_reg  <= '0;
                            res_avg_reg <= '0;
                            res_vld_reg <= 1'b0;
                            state_reg   <= ST_EMIT;
                        end
                        else
                        begin
                            cur_tr_reg  <= q_tr;
                            cur_pos_reg <= pos_eff;
                            state_reg   <= ST_UPDATE;
                        end
                    end
                end
                ST_UPDATE:
                begin
                    res_tr_reg <= cur_tr_reg;
                    if (filled_new >= period)
                    begin
                        quo_reg   <= {sum_new, atr_pkg::FRAC_BITS'(0)};
                        rem_reg   <= '0;
                        cnt_reg   <= CNT_W'(DW - 1);
                        state_reg <= ST_DIVIDE;
                    end
                    else
                    begin
                        res_avg_reg <= '0;
                        res_vld_reg <= 1'b0;
                        state_reg   <= ST_EMIT;
                    end
                end
                ST_DIVIDE:
                begin
                    quo_reg <= quo_next;
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == '0)
                    begin
                        res_avg_reg <= atr_pkg::AVG_W'(quo_next);
                        res_vld_reg <= 1'b1;
                        state_reg   <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (emit_load)
                    begin
                        out_tr_reg  <= atr_pkg::TR_W'(res_tr_reg);
                        out_avg_reg <= res_avg_reg;
                        out_vld_reg <= res_vld_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign true_range    = out_tr_reg;
    assign average_range = out_avg_reg;
    assign average_valid = out_vld_reg;

endmodule

[rtl/core/average_true_range.sv]
// ----------------------------------------------------------------------------
// Average true range over a simple moving window
// Bars enter on the input channel (in_valid, in_stall, bar_high, bar_low,
// bar_close); one result per bar leaves on the output channel (out_valid,
// out_stall, true_range, average_range, average_valid). A transfer takes place
// on a rising edge with valid high and stall low.
// The front part works out the true range in the cycle of the transfer and
// places it in a two-entry queue. The back part reads the old ring entry,
// updates the sum and, once the window is full, runs a restoring divider that
// produces one quotient bit per cycle. The back part works on one bar at a
// time; meanwhile the queue lets the front part take up to two more bars.
// The period register is written with cfg_wr_en and cfg_wr_data; the user
// must do so only while the block is idle, which the block does not enforce. A
// write clears the window. After reset the period is 14, the window is empty
// and the first bar only records its close.
// While the receiver stalls, the result is held in the output register; the
// back part finishes its next bar and the queue fills, after which in_stall
// is raised.
// ----------------------------------------------------------------------------
module average_true_range #(
    parameter int MAX_PERIOD = 64,
    parameter int PRICE_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [atr_pkg::CFG_W-1:0]         cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [31:0]                       bar_high,
    input  logic [31:0]                       bar_low,
    input  logic [31:0]                       bar_close,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [atr_pkg::TR_W-1:0]          true_range,
    output logic [atr_pkg::AVG_W-1:0]         average_range,
    output logic                              average_valid
);

    localparam int PW          = $clog2(MAX_PERIOD + 1);
    localparam int PERIOD_INIT = (atr_pkg::PERIOD_RESET > MAX_PERIOD) ?
                                 MAX_PERIOD : atr_pkg::PERIOD_RESET;

    logic [PW-1:0]         period_reg;
    logic [PW-1:0]         period_next;
    logic                  q_push;
    logic                  q_first;
    logic [PRICE_BITS-1:0] q_tr;
    logic                  q_full;
    logic                  q_pop;
    logic                  q_not_empty;
    logic [PRICE_BITS:0]   q_head;

    always_comb
    begin
        if (cfg_wr_data == '0)
        begin
            period_next = PW'(1);
        end
        else if (int'(cfg_wr_data) > MAX_PERIOD)
        begin
            period_next = PW'(MAX_PERIOD);
        end
        else
        begin
            period_next = PW'(cfg_wr_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PW'(PERIOD_INIT);
        end
        else if (cfg_wr_en)
        begin
            period_reg <= period_next;
        end
    end

    atr_front #(
        .PRICE_BITS (PRICE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .bar_high  (bar_high),
        .bar_low   (bar_low),
        .bar_close (bar_close),
        .q_push    (q_push),
        .q_first   (q_first),
        .q_tr      (q_tr),
        .q_full    (q_full)
    );

    atr_fifo #(
        .WIDTH (PRICE_BITS + 1),
        .DEPTH (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({q_first, q_tr}),
        .full      (q_full),
        .pop       (q_pop),
        .head_data (q_head),
        .not_empty (q_not_empty)
    );

    atr_back #(
        .MAX_PERIOD (MAX_PERIOD),
        .PRICE_BITS (PRICE_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .period        (period_reg),
        .cfg_clear     (cfg_wr_en),
        .q_not_empty   (q_not_empty),
        .q_first       (q_head[PRICE_BITS]),
        .q_tr          (q_head[PRICE_BITS-1:0]),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .true_range    (true_range),
        .average_range (average_range),
        .average_valid (average_valid)
    );

endmodule
